@@ src/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define HMR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, held off during reset
`define HMR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ src/hmr_pkg.sv @@
// Types and constants for the HTTP method recognizer
package hmr_pkg;

	localparam int HMR_COUNT_WIDTH = 16;
	localparam int BYTES_READ_W    = 16;

	localparam logic [7:0] CH_G  = 8'h47;
	localparam logic [7:0] CH_H  = 8'h48;
	localparam logic [7:0] CH_D  = 8'h44;
	localparam logic [7:0] CH_P  = 8'h50;
	localparam logic [7:0] CH_E  = 8'h45;
	localparam logic [7:0] CH_T  = 8'h54;
	localparam logic [7:0] CH_O  = 8'h4F;
	localparam logic [7:0] CH_U  = 8'h55;
	localparam logic [7:0] CH_A  = 8'h41;
	localparam logic [7:0] CH_S  = 8'h53;
	localparam logic [7:0] CH_L  = 8'h4C;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;

	localparam logic [1:0] STATUS_BUSY  = 2'd0;
	localparam logic [1:0] STATUS_DONE  = 2'd1;
	localparam logic [1:0] STATUS_ERROR = 2'd2;

	localparam logic [2:0] METHOD_NONE   = 3'd0;
	localparam logic [2:0] METHOD_GET    = 3'd1;
	localparam logic [2:0] METHOD_HEAD   = 3'd2;
	localparam logic [2:0] METHOD_POST   = 3'd3;
	localparam logic [2:0] METHOD_PUT    = 3'd4;
	localparam logic [2:0] METHOD_DELETE = 3'd5;

	typedef struct packed {
		logic       restart;
		logic [7:0] data_byte;
	} hmr_req_t;

	typedef struct packed {
		logic                    want_more;
		logic [1:0]              status;
		logic [2:0]              method_code;
		logic [BYTES_READ_W-1:0] bytes_read;
	} hmr_rsp_t;

endpackage

@@ src/hmr_parser.sv @@
// Method trie, sticky done/error state and saturating byte counter
module hmr_parser #(
	parameter int COUNT_WIDTH = hmr_pkg::HMR_COUNT_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  hmr_pkg::hmr_req_t req,
	output hmr_pkg::hmr_rsp_t rsp
);
	import hmr_pkg::*;

	typedef enum logic [4:0] {
		ST_START, ST_CR,
		ST_G, ST_GE, ST_GET,
		ST_H, ST_HE, ST_HEA, ST_HEAD,
		ST_P, ST_PO, ST_POS, ST_POST, ST_PU, ST_PUT,
		ST_D, ST_DE, ST_DEL, ST_DELE, ST_DELET, ST_DELETE,
		ST_DONE, ST_ERROR
	} parse_state_t;

	parse_state_t             state_q, st_base, st_nxt;
	logic [2:0]               method_q, meth_base, meth_nxt;
	logic [COUNT_WIDTH-1:0]   count_q, cnt_base, cnt_nxt;
	logic [COUNT_WIDTH+BYTES_READ_W-1:0] cnt_ext;
	logic [7:0]               b;

	assign b = req.data_byte;

	always_comb begin
		// restart acts before the byte is consumed
		st_base   = req.restart ? ST_START : state_q;
		meth_base = req.restart ? METHOD_NONE : method_q;
		cnt_base  = req.restart ? '0 : count_q;
		cnt_nxt   = (&cnt_base) ? cnt_base : cnt_base + COUNT_WIDTH'(1);
		st_nxt    = st_base;
		meth_nxt  = meth_base;
		case (st_base)
			ST_START: begin
				if (b == CH_G) st_nxt = ST_G;
				else if (b == CH_H) st_nxt = ST_H;
				else if (b == CH_D) st_nxt = ST_D;
				else if (b == CH_P) st_nxt = ST_P;
				else if (b == CH_CR) st_nxt = ST_CR;
				else if (b != CH_LF) st_nxt = ST_ERROR;
			end
			ST_CR:    st_nxt = (b == CH_LF) ? ST_START : ST_ERROR;
			ST_G:     st_nxt = (b == CH_E) ? ST_GE : ST_ERROR;
			ST_GE:    st_nxt = (b == CH_T) ? ST_GET : ST_ERROR;
			ST_H:     st_nxt = (b == CH_E) ? ST_HE : ST_ERROR;
			ST_HE:    st_nxt = (b == CH_A) ? ST_HEA : ST_ERROR;
			ST_HEA:   st_nxt = (b == CH_D) ? ST_HEAD : ST_ERROR;
			ST_P: begin
				if (b == CH_O) st_nxt = ST_PO;
				else if (b == CH_U) st_nxt = ST_PU;
				else st_nxt = ST_ERROR;
			end
			ST_PO:    st_nxt = (b == CH_S) ? ST_POS : ST_ERROR;
			ST_POS:   st_nxt = (b == CH_T) ? ST_POST : ST_ERROR;
			ST_PU:    st_nxt = (b == CH_T) ? ST_PUT : ST_ERROR;
			ST_D:     st_nxt = (b == CH_E) ? ST_DE : ST_ERROR;
			ST_DE:    st_nxt = (b == CH_L) ? ST_DEL : ST_ERROR;
			ST_DEL:   st_nxt = (b == CH_E) ? ST_DELE : ST_ERROR;
			ST_DELE:  st_nxt = (b == CH_T) ? ST_DELET : ST_ERROR;
			ST_DELET: st_nxt = (b == CH_E) ? ST_DELETE : ST_ERROR;
			ST_GET, ST_HEAD, ST_POST, ST_PUT, ST_DELETE: begin
				// trailing space closes the method
				if (b == CH_SP) begin
					st_nxt = ST_DONE;
					case (st_base)
						ST_GET:  meth_nxt = METHOD_GET;
						ST_HEAD: meth_nxt = METHOD_HEAD;
						ST_POST: meth_nxt = METHOD_POST;
						ST_PUT:  meth_nxt = METHOD_PUT;
						default: meth_nxt = METHOD_DELETE;
					endcase
				end else begin
					st_nxt = ST_ERROR;
				end
			end
			ST_DONE:  st_nxt = ST_DONE;
			default:  st_nxt = ST_ERROR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_START;
			method_q <= METHOD_NONE;
			count_q  <= '0;
		end else if (adv) begin
			state_q  <= st_nxt;
			method_q <= meth_nxt;
			count_q  <= cnt_nxt;
		end
	end

	assign cnt_ext = {{BYTES_READ_W{1'b0}}, cnt_nxt};

	always_comb begin
		if (st_nxt == ST_DONE) rsp.status = STATUS_DONE;
		else if (st_nxt == ST_ERROR) rsp.status = STATUS_ERROR;
		else rsp.status = STATUS_BUSY;
		rsp.want_more   = (rsp.status == STATUS_BUSY);
		rsp.method_code = meth_nxt;
		rsp.bytes_read  = cnt_ext[BYTES_READ_W-1:0];
	end

endmodule

@@ src/http_method_recognizer_top.sv @@
// Top level of the HTTP method recognizer: input stage, parser, result register
//
// Request bytes enter on the req channel (valid/ready), one per item, with a
// restart bit that returns the parser to its start state before that byte.
// Every accepted byte yields exactly one result on the rsp channel: want_more,
// status, method_code and a saturating bytes_read count.
// An accepted byte is captured in the input stage, then walks the trie and its
// result is captured in the result register when the input stage advances.
// Throughput: one byte per cycle while results are taken; the only loop is the
// trie state update, done as a byte moves from input stage to result register.
// When rsp_ready is low the result is held; the input stage still takes one
// more byte, then req_ready drops until the result is taken.
// Reset (arst_n low) empties both stages and puts the parser at start with no
// method and a zero count. Done and error are sticky until restart or reset.
module http_method_recognizer_top #(
	parameter int COUNT_WIDTH = hmr_pkg::HMR_COUNT_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  hmr_pkg::hmr_req_t req_data,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output hmr_pkg::hmr_rsp_t rsp_data
);
	import hmr_pkg::*;

	hmr_req_t req_s1;
	logic     vld_s1;
	hmr_rsp_t rsp_nxt;
	hmr_rsp_t rsp_q;
	logic     rsp_vld_q;
	logic     adv;

	// the input stage moves on when the result register is free or being drained
	assign adv       = vld_s1 && (!rsp_vld_q || rsp_ready);
	assign req_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req_ready) begin
			vld_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req_data;
		end
	end

	hmr_parser #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.req   (req_s1),
		.rsp   (rsp_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (adv) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp_data  = rsp_q;

endmodule

@@ src/hmr_checker.sv @@
// Port-level checks for the HTTP method recognizer, bound to the top level
`include "assert_macros.svh"

module hmr_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input hmr_pkg::hmr_req_t req_data,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input hmr_pkg::hmr_rsp_t rsp_data
);
	import hmr_pkg::*;

	// stalled result holds
	`HMR_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
	// want_more tracks the in-progress status
	`HMR_ASSERT_IMP(a_want_more, clk, arst_n, rsp_valid, rsp_data.want_more == (rsp_data.status == STATUS_BUSY))
	// a method is reported exactly when done
	`HMR_ASSERT_IMP(a_method_done, clk, arst_n, rsp_valid, (rsp_data.method_code != METHOD_NONE) == (rsp_data.status == STATUS_DONE))
	// a byte with restart counts as the first; its result lands once the sink is ready
	`HMR_ASSERT_NXT(a_restart_cnt, clk, arst_n, req_valid && req_ready && req_data.restart ##1 rsp_ready, rsp_valid && (rsp_data.bytes_read == 1))

endmodule

bind http_method_recognizer_top hmr_checker u_hmr_checker (.*);
